### rtl/fbd_pkg.sv
// Shared types, constants and lookup tables for the fractional baud divisor calculator.
// Depends on nothing; every other file imports it.
package fbd_pkg;

    // Field widths.
    localparam int CLK_W  = 28;
    localparam int BAUD_W = 24;
    localparam int DIV_W  = 16;
    localparam int FRAC_W = 8;
    localparam int STAT_W = 2;

    // Shared divider widths: a 38-bit dividend covers 1000 times a 28-bit value.
    localparam int DVD_W  = 38;
    localparam int DSR_W  = 29;
    localparam int STEP_W = 6;
    localparam logic [STEP_W-1:0] STEPS_NARROW = 6'd28;
    localparam logic [STEP_W-1:0] STEPS_WIDE   = 6'd38;

    // Ratio quotient in thousandths stays below 3000.
    localparam int QUOT_W = 12;

    // Fraction table.
    localparam int RATIO_TABLE_ENTRIES = 72;
    localparam int IDX_W = 7;
    localparam logic [IDX_W-1:0] IDX_LAST = 7'(RATIO_TABLE_ENTRIES - 1);

    localparam logic [CLK_W-1:0] CLK_RESET = 28'd96000000;

    // Status codes.
    localparam logic [STAT_W-1:0] STATUS_OK   = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_SAT  = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_ZERO = 2'd2;

    // Control and status between the sequencer and the shared divider.
    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
    } div_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_sts_t;

    // Fractional error of each MULVAL/DIVADDVAL pair, in thousandths.
    localparam logic [9:0] FRAC_ERR [RATIO_TABLE_ENTRIES] = '{
        10'd0,   10'd67,  10'd71,  10'd77,  10'd83,  10'd91,  10'd100, 10'd111, 10'd125,
        10'd133, 10'd143, 10'd154, 10'd167, 10'd182, 10'd200, 10'd214, 10'd222, 10'd231,
        10'd250, 10'd267, 10'd273, 10'd286, 10'd300, 10'd308, 10'd333, 10'd357, 10'd364,
        10'd375, 10'd385, 10'd400, 10'd417, 10'd429, 10'd444, 10'd455, 10'd462, 10'd467,
        10'd500, 10'd533, 10'd538, 10'd545, 10'd556, 10'd571, 10'd583, 10'd600, 10'd615,
        10'd625, 10'd636, 10'd643, 10'd667, 10'd692, 10'd700, 10'd714, 10'd727, 10'd733,
        10'd750, 10'd769, 10'd778, 10'd786, 10'd800, 10'd818, 10'd833, 10'd846, 10'd857,
        10'd867, 10'd875, 10'd889, 10'd900, 10'd909, 10'd917, 10'd923, 10'd929, 10'd933
    };

    // Fraction byte paired with each table entry.
    localparam logic [FRAC_W-1:0] FRAC_CODE [RATIO_TABLE_ENTRIES] = '{
        8'h10, 8'hf1, 8'he1, 8'hd1, 8'hc1, 8'hb1, 8'ha1, 8'h91, 8'h81,
        8'hf2, 8'h71, 8'hd2, 8'h61, 8'hb2, 8'h51, 8'he3, 8'h92, 8'hd3,
        8'h41, 8'hf4, 8'hb3, 8'h72, 8'ha3, 8'hd4, 8'h31, 8'he5, 8'hb4,
        8'h83, 8'hd5, 8'h52, 8'hc5, 8'h73, 8'h94, 8'hb5, 8'hd6, 8'hf7,
        8'h21, 8'hf8, 8'hd7, 8'hb6, 8'h95, 8'h74, 8'hc7, 8'h53, 8'hd8,
        8'h85, 8'hb7, 8'he9, 8'h32, 8'hd9, 8'ha7, 8'h75, 8'hb8, 8'hfb,
        8'h43, 8'hda, 8'h97, 8'heb, 8'h54, 8'hb9, 8'h65, 8'hdb, 8'h76,
        8'hfd, 8'h87, 8'h98, 8'ha9, 8'hba, 8'hcb, 8'hdc, 8'hed, 8'hfe
    };

endpackage

### rtl/fbd_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on fbd_pkg for widths and the control/status structs.
module fbd_div
    import fbd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  div_ctl_t         ctl,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DSR_W-1:0] divisor,
    output div_sts_t         sts,
    output logic [DVD_W-1:0] quotient,
    output logic [DSR_W-1:0] remainder
);

    logic [DVD_W-1:0]  dvd_reg;
    logic [DSR_W-1:0]  dsr_reg;
    logic [DSR_W-1:0]  rem_reg;
    logic [DVD_W-1:0]  quo_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [DSR_W:0] rem_shift;
    logic [DSR_W:0] rem_diff;
    logic           fits;

    // One compare-subtract step: bring down the next dividend bit.
    assign rem_shift = {rem_reg, dvd_reg[DVD_W-1]};
    assign rem_diff  = rem_shift - {1'b0, dsr_reg};
    assign fits      = (rem_shift >= {1'b0, dsr_reg});

    // Control: step counter and done pulse.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            // Done pulses right after the last step.
            done_reg <= busy_reg && !ctl.start && (cnt_reg == STEP_W'(1));
            if (ctl.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= ctl.steps;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // Datapath: operands, partial remainder and quotient shift register.
    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            dvd_reg <= dividend;
            dsr_reg <= divisor;
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[DVD_W-2:0], 1'b0};
            rem_reg <= fits ? rem_diff[DSR_W-1:0] : rem_shift[DSR_W-1:0];
            quo_reg <= {quo_reg[DVD_W-2:0], fits};
        end
    end

    assign sts.busy  = busy_reg;
    assign sts.done  = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

### rtl/fbd_match.sv
// Nearest-entry search over the fractional error table, one entry per cycle.
// Depends on fbd_pkg for the tables and widths.
module fbd_match
    import fbd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [QUOT_W-1:0] quot,
    output logic              done,
    output logic [FRAC_W-1:0] code
);

    logic             busy_reg;
    logic             done_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] best_reg;
    logic [9:0]       bdist_reg;

    logic [10:0]       target;
    logic [QUOT_W-1:0] gap;
    logic              closer;

    // Distance between the entry (offset by one thousand) and the ratio quotient.
    assign target = {1'b0, FRAC_ERR[idx_reg]} + 11'd1000;
    assign gap    = (quot >= {1'b0, target}) ? (quot - {1'b0, target})
                                             : ({1'b0, target} - quot);
    assign closer = (gap < {2'b00, bdist_reg});

    // Scan the table; only a strictly smaller distance replaces the best entry.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            idx_reg   <= '0;
            best_reg  <= '0;
            bdist_reg <= 10'd1000;
        end
        else
        begin
            // Done pulses right after the last entry is compared.
            done_reg <= busy_reg && !start && (idx_reg == IDX_LAST);
            if (start)
            begin
                busy_reg  <= 1'b1;
                idx_reg   <= '0;
                best_reg  <= '0;
                bdist_reg <= 10'd1000;
            end
            else if (busy_reg)
            begin
                if (closer)
                begin
                    best_reg  <= idx_reg;
                    bdist_reg <= gap[9:0];
                end
                if (idx_reg == IDX_LAST)
                begin
                    busy_reg <= 1'b0;
                end
                else
                begin
                    idx_reg <= idx_reg + 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign code = FRAC_CODE[best_reg];

endmodule

### rtl/fractional_baud_divisor_calc_top.sv
// Top level of the fractional baud divisor calculator: sequencer, shared multiplier,
// configuration register and result register. Depends on fbd_pkg, fbd_div, fbd_match.
//
// One baud rate is taken at a time and produces one result. A zero rate goes straight from
// its transfer to S_DONE; otherwise the work runs as a chain of serial divisions on one
// shared 38-bit restoring divider (28 or 38 steps each, plus the start and done handshake)
// and one shared 28x24 multiplier and, where a fraction is used, a scan of the 72-entry
// fraction table. A rate that needs no fraction is answered after the thousandths division,
// one whose one-and-a-half divisor comes out zero after the division that yields it, and one
// that uses the fraction after the table scan. in_ready is high only while no item is in
// progress and no clock write is offered; a finished result sits in the output register
// until taken, and a new item may be accepted while it waits. The clock register is
// written only while the block is idle.
module fractional_baud_divisor_calc_top
    import fbd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CLK_W-1:0]  peripheral_clock_hz,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [BAUD_W-1:0] baud_rate,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [DIV_W-1:0]  divisor_latch,
    output logic [FRAC_W-1:0] fraction_byte,
    output logic              uses_fraction,
    output logic [STAT_W-1:0] status
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV_Q,
        S_MUL_T,
        S_DIV_T,
        S_DIV_V,
        S_MUL_DV,
        S_MUL_P,
        S_DIV_F,
        S_MATCH,
        S_DONE
    } state_t;

    state_t state_reg;

    logic [CLK_W-1:0]  clk_hz_reg;
    logic [BAUD_W-1:0] baud_reg;
    logic [CLK_W-1:0]  d_reg;
    logic [CLK_W-1:0]  q_reg;
    logic [BAUD_W-1:0] v_reg;
    logic [CLK_W-1:0]  div_reg;
    logic [FRAC_W-1:0] frac_reg;
    logic              use_frac_reg;
    logic              zero_reg;

    // Divider operand registers and start pulse.
    logic              div_start_reg;
    logic              div_start_next;
    logic [STEP_W-1:0] steps_reg;
    logic [DVD_W-1:0]  dvd_op_reg;
    logic [DSR_W-1:0]  dsr_op_reg;
    logic              match_start_reg;
    logic              match_start_next;
    logic [QUOT_W-1:0] quot_reg;

    // Result register.
    logic              out_valid_reg;
    logic [DIV_W-1:0]  dl_out_reg;
    logic [FRAC_W-1:0] frac_out_reg;
    logic              use_out_reg;
    logic [STAT_W-1:0] stat_out_reg;

    div_ctl_t          div_ctl;
    div_sts_t          div_sts;
    logic [DVD_W-1:0]  div_quo;
    logic [DSR_W-1:0]  div_rem;
    logic              match_done;
    logic [FRAC_W-1:0] match_code;

    logic [CLK_W-1:0]  mul_a;
    logic [BAUD_W-1:0] mul_b;
    logic [51:0]       prod;
    logic              saturate;
    logic              t_mid;

    assign div_ctl.start = div_start_reg;
    assign div_ctl.steps = steps_reg;

    fbd_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (div_ctl),
        .dividend  (dvd_op_reg),
        .divisor   (dsr_op_reg),
        .sts       (div_sts),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    fbd_match u_match (
        .clk   (clk),
        .rst_n (rst_n),
        .start (match_start_reg),
        .quot  (quot_reg),
        .done  (match_done),
        .code  (match_code)
    );

    // Shared multiplier: remainder times 1000, d times v, clock times 1000.
    always_comb
    begin
        unique case (state_reg)
            S_MUL_T:
            begin
                mul_a = div_rem[CLK_W-1:0];
                mul_b = BAUD_W'(1000);
            end
            S_MUL_DV:
            begin
                mul_a = d_reg;
                mul_b = v_reg;
            end
            S_MUL_P:
            begin
                mul_a = clk_hz_reg;
                mul_b = BAUD_W'(1000);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod     = mul_a * mul_b;
    assign saturate = (div_reg > CLK_W'(16'hFFFF));

    // Thousandths between the two thresholds call for the fractional divider.
    assign t_mid = (div_quo[9:0] > 10'd10) && (div_quo[9:0] <= 10'd990);

    // Start pulses for the shared divider and the table scan.
    always_comb
    begin
        div_start_next   = 1'b0;
        match_start_next = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                div_start_next = in_valid && in_ready && (baud_rate != '0);
            end
            S_MUL_T, S_MUL_P:
            begin
                div_start_next = 1'b1;
            end
            S_DIV_T:
            begin
                div_start_next = div_sts.done && t_mid;
            end
            S_DIV_F:
            begin
                match_start_next = div_sts.done;
            end
            default:
            begin
            end
        endcase
    end

    // Sequencer with its registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            clk_hz_reg      <= CLK_RESET;
            div_start_reg   <= 1'b0;
            match_start_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
            baud_reg        <= '0;
            d_reg           <= '0;
            q_reg           <= '0;
            v_reg           <= '0;
            div_reg         <= '0;
            frac_reg        <= '0;
            use_frac_reg    <= 1'b0;
            zero_reg        <= 1'b0;
            steps_reg       <= '0;
            dvd_op_reg      <= '0;
            dsr_op_reg      <= '0;
            quot_reg        <= '0;
            dl_out_reg      <= '0;
            frac_out_reg    <= '0;
            use_out_reg     <= 1'b0;
            stat_out_reg    <= STATUS_OK;
        end
        else
        begin
            div_start_reg   <= div_start_next;
            match_start_reg <= match_start_next;

            // Output transfer frees the result register unless a new result loads now.
            if (out_valid_reg && out_ready && (state_reg != S_DONE))
            begin
                out_valid_reg <= 1'b0;
            end

            // Configuration write.
            if (cfg_valid && cfg_ready)
            begin
                clk_hz_reg <= peripheral_clock_hz;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && in_ready)
                    begin
                        baud_reg     <= baud_rate;
                        d_reg        <= {baud_rate, 4'b0};
                        frac_reg     <= '0;
                        use_frac_reg <= 1'b0;
                        div_reg      <= '0;
                        if (baud_rate == '0)
                        begin
                            zero_reg  <= 1'b1;
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            zero_reg   <= 1'b0;
                            dvd_op_reg <= {clk_hz_reg, 10'b0};
                            dsr_op_reg <= {1'b0, baud_rate, 4'b0};
                            steps_reg  <= STEPS_NARROW;
                            state_reg  <= S_DIV_Q;
                        end
                    end
                end
                S_DIV_Q:
                begin
                    if (div_sts.done)
                    begin
                        q_reg     <= div_quo[CLK_W-1:0];
                        state_reg <= S_MUL_T;
                    end
                end
                S_MUL_T:
                begin
                    // Thousandths: remainder times 1000 over d.
                    dvd_op_reg <= prod[DVD_W-1:0];
                    dsr_op_reg <= {1'b0, d_reg};
                    steps_reg  <= STEPS_WIDE;
                    state_reg  <= S_DIV_T;
                end
                S_DIV_T:
                begin
                    if (div_sts.done)
                    begin
                        if (div_quo[9:0] > 10'd990)
                        begin
                            div_reg   <= q_reg + 1'b1;
                            state_reg <= S_DONE;
                        end
                        else if (div_quo[9:0] > 10'd10)
                        begin
                            dvd_op_reg <= {clk_hz_reg, 10'b0};
                            dsr_op_reg <= {1'b0, baud_reg, 4'b0} + {2'b0, baud_reg, 3'b0};
                            steps_reg  <= STEPS_NARROW;
                            state_reg  <= S_DIV_V;
                        end
                        else
                        begin
                            div_reg   <= q_reg;
                            state_reg <= S_DONE;
                        end
                    end
                end
                S_DIV_V:
                begin
                    if (div_sts.done)
                    begin
                        v_reg <= div_quo[BAUD_W-1:0];
                        if (div_quo[BAUD_W-1:0] == '0)
                        begin
                            div_reg   <= q_reg;
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            state_reg <= S_MUL_DV;
                        end
                    end
                end
                S_MUL_DV:
                begin
                    // d times v never exceeds the clock, so it fits the divisor.
                    dsr_op_reg <= prod[DSR_W-1:0];
                    state_reg  <= S_MUL_P;
                end
                S_MUL_P:
                begin
                    dvd_op_reg <= prod[DVD_W-1:0];
                    steps_reg  <= STEPS_WIDE;
                    state_reg  <= S_DIV_F;
                end
                S_DIV_F:
                begin
                    if (div_sts.done)
                    begin
                        quot_reg  <= div_quo[QUOT_W-1:0];
                        state_reg <= S_MATCH;
                    end
                end
                S_MATCH:
                begin
                    if (match_done)
                    begin
                        frac_reg     <= match_code;
                        use_frac_reg <= 1'b1;
                        div_reg      <= {4'b0, v_reg};
                        state_reg    <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    // Load the result once the output register is free.
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        frac_out_reg  <= frac_reg;
                        use_out_reg   <= use_frac_reg;
                        dl_out_reg    <= saturate ? 16'hFFFF : div_reg[DIV_W-1:0];
                        if (zero_reg)
                        begin
                            stat_out_reg <= STATUS_ZERO;
                        end
                        else if (saturate)
                        begin
                            stat_out_reg <= STATUS_SAT;
                        end
                        else
                        begin
                            stat_out_reg <= STATUS_OK;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // A clock write offered in the idle state goes first, so an item never straddles it.
    assign in_ready      = (state_reg == S_IDLE) && !cfg_valid;
    assign cfg_ready     = (state_reg == S_IDLE);
    assign out_valid     = out_valid_reg;
    assign divisor_latch = dl_out_reg;
    assign fraction_byte = frac_out_reg;
    assign uses_fraction = use_out_reg;
    assign status        = stat_out_reg;

endmodule

### rtl/fbd_checker.sv
// Port-level checks for the fractional baud divisor calculator and their bind.
// Depends on fbd_pkg for status codes; binds to fractional_baud_divisor_calc_top.
module fbd_checker
    import fbd_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input logic [DIV_W-1:0]  divisor_latch,
    input logic [FRAC_W-1:0] fraction_byte,
    input logic              uses_fraction,
    input logic [STAT_W-1:0] status
);

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(divisor_latch) && $stable(status))
        else $error("result changed while stalled");

    // Only one item is in progress at a time.
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while an item is in progress");

    // A zero rate gives an all-zero result.
    a_zero_rate: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == STATUS_ZERO |->
            divisor_latch == '0 && fraction_byte == '0 && !uses_fraction)
        else $error("zero rate result not cleared");

    // A saturated divisor reads as all ones.
    a_saturate: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == STATUS_SAT |-> divisor_latch == 16'hFFFF)
        else $error("saturated divisor not at maximum");

    // The fraction byte is zero whenever it is unused.
    a_frac_unused: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !uses_fraction |-> fraction_byte == '0)
        else $error("fraction byte set while unused");

endmodule

bind fractional_baud_divisor_calc_top fbd_checker u_fbd_checker (.*);

### bench/fractional_baud_divisor_calc_top_test.sv
// Self-checking bench for fractional_baud_divisor_calc_top: directed and random baud rates
// under several clock settings, checked against an in-bench divisor predictor.
// Depends on fbd_pkg and the RTL of the block.
module fractional_baud_divisor_calc_top_test;
    import fbd_pkg::*;

    typedef struct packed {
        logic [DIV_W-1:0]  divisor;
        logic [FRAC_W-1:0] fraction;
        logic              uses;
        logic [STAT_W-1:0] code;
    } baud_result_t;

    typedef struct packed {
        logic [BAUD_W-1:0] baud;
        logic              has_typed;
        baud_result_t      result;
    } directed_row_t;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    localparam int HOLD_CYCLES     = 600;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int DRAIN_CYCLES    = 20;
    localparam int CFG_SETTLE      = 4;
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 50;
    localparam logic [CLK_W-1:0]  RESET_CLOCK_HZ = 28'd96000000;
    localparam logic [CLK_W-1:0]  MAX_CLOCK_HZ   = 28'hFFFFFFF;
    localparam logic [BAUD_W-1:0] MAX_BAUD       = 24'hFFFFFF;
    localparam longint unsigned   DIV_LIMIT      = 65535;
    localparam int                TABLE_SIZE     = 72;

    // Fractional error of each MULVAL/DIVADDVAL pair, in thousandths.
    localparam logic [9:0] ERR_MILLI [TABLE_SIZE] = '{
        10'd0,   10'd67,  10'd71,  10'd77,  10'd83,  10'd91,  10'd100, 10'd111, 10'd125,
        10'd133, 10'd143, 10'd154, 10'd167, 10'd182, 10'd200, 10'd214, 10'd222, 10'd231,
        10'd250, 10'd267, 10'd273, 10'd286, 10'd300, 10'd308, 10'd333, 10'd357, 10'd364,
        10'd375, 10'd385, 10'd400, 10'd417, 10'd429, 10'd444, 10'd455, 10'd462, 10'd467,
        10'd500, 10'd533, 10'd538, 10'd545, 10'd556, 10'd571, 10'd583, 10'd600, 10'd615,
        10'd625, 10'd636, 10'd643, 10'd667, 10'd692, 10'd700, 10'd714, 10'd727, 10'd733,
        10'd750, 10'd769, 10'd778, 10'd786, 10'd800, 10'd818, 10'd833, 10'd846, 10'd857,
        10'd867, 10'd875, 10'd889, 10'd900, 10'd909, 10'd917, 10'd923, 10'd929, 10'd933
    };

    // Divider byte that goes with each error entry above.
    localparam logic [7:0] PAIR_CODE [TABLE_SIZE] = '{
        8'h10, 8'hf1, 8'he1, 8'hd1, 8'hc1, 8'hb1, 8'ha1, 8'h91, 8'h81,
        8'hf2, 8'h71, 8'hd2, 8'h61, 8'hb2, 8'h51, 8'he3, 8'h92, 8'hd3,
        8'h41, 8'hf4, 8'hb3, 8'h72, 8'ha3, 8'hd4, 8'h31, 8'he5, 8'hb4,
        8'h83, 8'hd5, 8'h52, 8'hc5, 8'h73, 8'h94, 8'hb5, 8'hd6, 8'hf7,
        8'h21, 8'hf8, 8'hd7, 8'hb6, 8'h95, 8'h74, 8'hc7, 8'h53, 8'hd8,
        8'h85, 8'hb7, 8'he9, 8'h32, 8'hd9, 8'ha7, 8'h75, 8'hb8, 8'hfb,
        8'h43, 8'hda, 8'h97, 8'heb, 8'h54, 8'hb9, 8'h65, 8'hdb, 8'h76,
        8'hfd, 8'h87, 8'h98, 8'ha9, 8'hba, 8'hcb, 8'hdc, 8'hed, 8'hfe
    };

    // Directed rates, all run at the reset clock of 96 MHz. Rows with a typed result check
    // the reset value of the clock register as well.
    localparam int DIRECTED_ROWS = 18;
    localparam directed_row_t DIRECTED [DIRECTED_ROWS] = '{
        // Zero rate is flagged.
        '{24'd0,        1'b1, '{16'd0,     8'h00, 1'b0, STATUS_ZERO}},
        // Slowest rate saturates the divisor.
        '{24'd1,        1'b1, '{16'hFFFF,  8'h00, 1'b0, STATUS_SAT}},
        // Fastest rate: quotient and the one-and-a-half divisor are both zero.
        '{MAX_BAUD,     1'b1, '{16'd0,     8'h00, 1'b0, STATUS_OK}},
        // Exact divisions.
        '{24'd375000,   1'b1, '{16'd16,    8'h00, 1'b0, STATUS_OK}},
        '{24'd6000000,  1'b1, '{16'd1,     8'h00, 1'b0, STATUS_OK}},
        '{24'd3000000,  1'b1, '{16'd2,     8'h00, 1'b0, STATUS_OK}},
        // A saturated divisor that still carries a fraction, then standard rates.
        '{24'd7,        1'b0, '0},
        '{24'd9600,     1'b0, '0},
        '{24'd57600,    1'b0, '0},
        '{24'd115200,   1'b0, '0},
        // Thousandths just above and at the round-up threshold.
        '{24'd60005,    1'b0, '0},
        '{24'd60006,    1'b0, '0},
        // Thousandths at and just above the low threshold.
        '{24'd59994,    1'b0, '0},
        '{24'd59993,    1'b0, '0},
        // No table entry within a distance of 1000.
        '{24'd2013423,  1'b0, '0},
        // Ratio halfway between two table entries: the first one wins.
        '{24'd3702561,  1'b0, '0},
        '{24'd8388608,  1'b0, '0},
        '{24'd4194303,  1'b0, '0}
    };

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [CLK_W-1:0]  peripheral_clock_hz = '0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic [BAUD_W-1:0] baud_rate = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [DIV_W-1:0]  divisor_latch;
    logic [FRAC_W-1:0] fraction_byte;
    logic              uses_fraction;
    logic [STAT_W-1:0] status;

    // Bench state: the clock setting as the block should hold it, results still owed,
    // and the typed result for the rate currently offered, if any.
    logic [CLK_W-1:0] clock_model = RESET_CLOCK_HZ;
    baud_result_t     pending_results [$];
    logic             typed_pending = 1'b0;
    baud_result_t     typed_result = '0;
    int               mismatches = 0;
    int               quiet_cycles = 0;
    int               sender_idle_pct = 0;
    int               receiver_stall_pct = 0;
    int               holds_asked = 0;
    int               holds_done = 0;
    int               hold_left = 0;

    fractional_baud_divisor_calc_top dut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .peripheral_clock_hz (peripheral_clock_hz),
        .in_valid            (in_valid),
        .in_ready            (in_ready),
        .baud_rate           (baud_rate),
        .out_valid           (out_valid),
        .out_ready           (out_ready),
        .divisor_latch       (divisor_latch),
        .fraction_byte       (fraction_byte),
        .uses_fraction       (uses_fraction),
        .status              (status)
    );

    // Clock with a period of 20.
    always #10 clk = ~clk;

    // Divisor latch, fraction byte and status for one rate at the given clock.
    function automatic baud_result_t divisor_for(input logic [CLK_W-1:0] pclk,
                                                 input logic [BAUD_W-1:0] baud);
        longint unsigned p, b, d, q, t, v, dv;
        longint          f, e, gap, best_dist;
        int              k, best;
        baud_result_t    r;
        r = '0;
        p = 64'(pclk);
        b = 64'(baud);
        if (b == 0) begin
            r.code = STATUS_ZERO;
            return r;
        end
        d  = 16 * b;
        q  = p / d;
        t  = ((p % d) * 1000) / d;
        dv = q;
        if (t > 990) begin
            dv = q + 1;
        end
        else if (t > 10) begin
            v = p / (24 * b);
            if (v != 0) begin
                // Match the ratio against the table: nearest entry, first on ties.
                f = longint'((p * 1000) / (d * v)) - 1000;
                best = 0;
                best_dist = 1000;
                for (k = 0; k < TABLE_SIZE; k++) begin
                    e = longint'(ERR_MILLI[k]);
                    gap = (f < e) ? (e - f) : (f - e);
                    if (gap < best_dist) begin
                        best = k;
                        best_dist = gap;
                    end
                end
                r.fraction = PAIR_CODE[best];
                r.uses = 1'b1;
                dv = v;
            end
        end
        if (dv > DIV_LIMIT) begin
            dv = DIV_LIMIT;
            r.code = STATUS_SAT;
        end
        r.divisor = dv[DIV_W-1:0];
        return r;
    endfunction

    // Random rate: mostly standard rates and rates close to an integer divisor, plus
    // full-range values, very slow rates and the odd zero.
    function automatic logic [BAUD_W-1:0] random_baud(input logic [CLK_W-1:0] pclk);
        longint unsigned standard [16] = '{300, 1200, 2400, 4800, 9600, 19200, 38400,
                                           57600, 115200, 230400, 250000, 460800,
                                           921600, 1000000, 1500000, 3000000};
        longint unsigned b;
        int              pick;
        pick = $urandom_range(0, 99);
        if (pick < 4)
            b = 0;
        else if (pick < 24)
            b = 64'($urandom_range(0, MAX_BAUD));
        else if (pick < 54)
            b = standard[$urandom_range(0, 15)] + 64'($urandom_range(0, 1));
        else if (pick < 79)
            b = longint'(pclk) / (16 * longint'($urandom_range(1, 4096)))
                + 64'($urandom_range(0, 2));
        else
            b = 64'($urandom_range(1, 3000));
        if (b > MAX_BAUD)
            b = MAX_BAUD;
        return b[BAUD_W-1:0];
    endfunction

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    // Offer one rate and hold it until the block takes it. Starts and ends at a falling edge.
    task automatic offer_baud(input logic [BAUD_W-1:0] b, input logic has_typed,
                              input baud_result_t res);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        typed_pending = has_typed;
        typed_result  = res;
        in_valid  <= 1'b1;
        baud_rate <= b;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
    endtask

    // Stop offering and wait until every owed result has come back.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge clk);
    endtask

    // Write the clock register while the block is idle.
    task automatic write_clock(input logic [CLK_W-1:0] hz);
        wait_drained();
        repeat (CFG_SETTLE) @(negedge clk);
        cfg_valid           <= 1'b1;
        peripheral_clock_hz <= hz;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Result side: random stalls, or a long hold-off when one has been asked for.
    always @(negedge clk) begin
        if (hold_left > 0) begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (holds_asked != holds_done) begin
            out_ready  <= 1'b0;
            holds_done <= holds_done + 1;
            hold_left  <= HOLD_CYCLES;
        end
        else begin
            out_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
        end
    end

    // Monitor: checks each result transfer, tracks the clock register, predicts each
    // accepted rate and watches for a stalled run.
    always @(posedge clk) begin
        baud_result_t want;
        if (rst_n) begin
            if (out_valid && out_ready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected result, divisor", divisor_latch, 0);
                end
                else begin
                    want = pending_results.pop_front();
                    if (divisor_latch !== want.divisor)
                        report_mismatch("divisor_latch", divisor_latch, want.divisor);
                    if (fraction_byte !== want.fraction)
                        report_mismatch("fraction_byte", fraction_byte, want.fraction);
                    if (uses_fraction !== want.uses)
                        report_mismatch("uses_fraction", uses_fraction, want.uses);
                    if (status !== want.code)
                        report_mismatch("status", status, want.code);
                end
            end
            if (cfg_valid && cfg_ready)
                clock_model = peripheral_clock_hz;
            if (in_valid && in_ready)
                pending_results.push_back(typed_pending ? typed_result
                                                        : divisor_for(clock_model, baud_rate));

            if ((out_valid && out_ready) || (cfg_valid && cfg_ready) || (in_valid && in_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // Stimulus: directed rows at the reset clock, then random phases over several clocks.
    initial begin
        logic [CLK_W-1:0] hz;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int i = 0; i < DIRECTED_ROWS; i++)
            offer_baud(DIRECTED[i].baud, DIRECTED[i].has_typed, DIRECTED[i].result);

        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0:       hz = MAX_CLOCK_HZ;
                1:       hz = 28'd1;
                2:       hz = 28'd14745600;
                3:       hz = 28'd1843200;
                5:       hz = 28'd25000000;
                7:       hz = RESET_CLOCK_HZ;
                default: hz = CLK_W'($urandom_range(1, MAX_CLOCK_HZ));
            endcase
            write_clock(hz);

            case (idle_mode_t'(phase % 4))
                IDLE_NONE:     begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                IDLE_SENDER:   begin sender_idle_pct = 83; receiver_stall_pct = 0;  end
                IDLE_RECEIVER: begin sender_idle_pct = 0;  receiver_stall_pct = 83; end
                default:       begin sender_idle_pct = 12; receiver_stall_pct = 12; end
            endcase

            for (int item = 0; item < ITEMS_PER_PHASE; item++) begin
                // Midway through each phase, let the block run completely dry once.
                if (item == ITEMS_PER_PHASE / 2)
                    wait_drained();
                // Long result hold-off while rates keep coming, so the block backs up.
                if (phase == 2 && item == 5)
                    holds_asked++;
                offer_baud(random_baud(clock_model), 1'b0, '0);
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (pending_results.size() != 0)
            report_mismatch("results never delivered", pending_results.size(), 0);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

### fractional_baud_divisor_calc_top.f
rtl/fbd_pkg.sv
rtl/fbd_div.sv
rtl/fbd_match.sv
rtl/fractional_baud_divisor_calc_top.sv
rtl/fbd_checker.sv
bench/fractional_baud_divisor_calc_top_test.sv
